[rtl/phvc_pkg.sv]
// ----------------------------------------------------------------------------
// phvc_pkg: shared types and constants of the position-hold velocity controller
// Request and result layouts, register indexes, divider interface, saturation.
// ----------------------------------------------------------------------------
package phvc_pkg;

	localparam int AVG_POINTS = 8;
	localparam int HIST_LEN   = AVG_POINTS + 1;
	localparam int FILL_W     = $clog2(HIST_LEN + 1);
	localparam int CNT_W      = (AVG_POINTS > 1) ? $clog2(AVG_POINTS) : 1;

	localparam logic signed [31:0] ONE_Q   = 32'sd65536;
	localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
	localparam logic signed [51:0] NUM_LIM = 52'sd70368744177663;

	localparam logic [2:0] CFG_LAW      = 3'd0;
	localparam logic [2:0] CFG_TAU      = 3'd1;
	localparam logic [2:0] CFG_TARGET   = 3'd2;
	localparam logic [2:0] CFG_SCALE    = 3'd3;
	localparam logic [2:0] CFG_LIMIT    = 3'd4;
	localparam logic [2:0] CFG_CAP      = 3'd5;
	localparam logic [2:0] CFG_BLEND    = 3'd6;
	localparam logic [2:0] CFG_INIT_VEL = 3'd7;

	localparam logic [1:0] LAW_NONE   = 2'd0;
	localparam logic [1:0] LAW_LINEAR = 2'd1;
	localparam logic [1:0] LAW_QUAD1  = 2'd2;
	localparam logic [1:0] LAW_QUAD2  = 2'd3;

	typedef struct packed {
		logic signed [31:0] measured_position;
		logic        [30:0] time_step;
		logic        [47:0] current_time;
		logic               first_step;
	} in_t;

	typedef struct packed {
		logic signed [31:0] inlet_velocity;
		logic signed [31:0] velocity_rate;
		logic signed [31:0] speed_estimate;
		logic signed [31:0] local_speed;
		logic signed [31:0] clamped_velocity;
		logic               divide_fault;
	} out_t;

	typedef struct packed {
		logic               start;
		logic signed [51:0] num;
		logic signed [49:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               fault;
		logic signed [31:0] quo;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
		logic signed [31:0] r;
		if (x > 52'(Q_MAX)) begin
			r = Q_MAX;
		end else if (x < 52'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

[rtl/phvc_div.sv]
// ----------------------------------------------------------------------------
// phvc_div: iterative Q16.16 divider
// Computes sat32((clamp(num) * 2^16) / den), truncated toward zero, one
// quotient bit per cycle after an overflow check; a zero divisor saturates.
// ----------------------------------------------------------------------------
module phvc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  phvc_pkg::div_req_t  req,
	output phvc_pkg::div_rsp_t  rsp
);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_CHK  = 3'b010,
		D_RUN  = 3'b100
	} dstate_t;

	dstate_t            state_q;
	logic [61:0]        mag_q;
	logic [48:0]        dmag_q;
	logic [48:0]        rem_q;
	logic [30:0]        lo_q;
	logic [4:0]         cnt_q;
	logic               neg_q;
	logic               done_q;
	logic               fault_q;
	logic signed [31:0] quo_q;

	logic signed [51:0] numc;
	logic signed [51:0] numa;
	logic signed [49:0] dena;
	logic [49:0]        rem2;
	logic [49:0]        remd;
	logic               qbit;
	logic [30:0]        qnext;

	always_comb begin
		numc = req.num;
		if (req.num > phvc_pkg::NUM_LIM) begin
			numc = phvc_pkg::NUM_LIM;
		end else if (req.num < -phvc_pkg::NUM_LIM) begin
			numc = -phvc_pkg::NUM_LIM;
		end
		numa = (numc < 0) ? -numc : numc;
		dena = (req.den < 0) ? -req.den : req.den;
		rem2 = {rem_q, lo_q[30]};
		remd = rem2 - {1'b0, dmag_q};
		qbit = (rem2 >= {1'b0, dmag_q});
		qnext = {lo_q[29:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			fault_q <= 1'b0;
			quo_q   <= '0;
			mag_q   <= '0;
			dmag_q  <= '0;
			rem_q   <= '0;
			lo_q    <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						fault_q <= 1'b0;
						if (req.den == 0) begin
							fault_q <= 1'b1;
							done_q  <= 1'b1;
							if (numc > 0) begin
								quo_q <= phvc_pkg::Q_MAX;
							end else if (numc < 0) begin
								quo_q <= phvc_pkg::Q_MIN;
							end else begin
								quo_q <= '0;
							end
						end else begin
							mag_q   <= {numa[45:0], 16'b0};
							dmag_q  <= dena[48:0];
							neg_q   <= (numc < 0) ^ (req.den < 0);
							state_q <= D_CHK;
						end
					end
				end
				D_CHK: begin
					// A quotient of 2^31 or more saturates without iterating.
					if ({18'b0, mag_q} >= {dmag_q, 31'b0}) begin
						quo_q   <= neg_q ? phvc_pkg::Q_MIN : phvc_pkg::Q_MAX;
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						rem_q   <= {18'b0, mag_q[61:31]};
						lo_q    <= mag_q[30:0];
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= qbit ? remd[48:0] : rem2[48:0];
					lo_q  <= qnext;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						quo_q   <= neg_q ? -signed'({1'b0, qnext}) : signed'({1'b0, qnext});
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.fault = fault_q;
	assign rsp.quo   = quo_q;

endmodule

[rtl/position_hold_velocity_controller.sv]
// ----------------------------------------------------------------------------
// position_hold_velocity_controller: velocity control update per request
// Advances the inlet velocity, estimates the front speed over a history
// window and applies one of three control laws, or none, with step and cap limits.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  in       | in_valid, in_stall, in_data     | request in
//  out      | out_valid, out_stall, out_data  | result out
//  cfg      | cfg_we, cfg_index, cfg_data     | register write
//
// A request runs from acceptance to its result through the shared divider
// (up to eight quotients per request; a zero divisor or a quotient that
// saturates ends a division early) and the shared multiplier, which walks
// the eight window terms. The next request is taken only once the
// sequencer is back in its idle state.
// Reset is asynchronous; no clearing pass is needed. A new request is taken
// while a result waits in the output register; a finished request holds in its
// last state while the previous result is still stalled.
module position_hold_velocity_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  phvc_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output phvc_pkg::out_t      out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [37:0] {
		S_IDLE  = 38'(1) << 0,  S_ADV   = 38'(1) << 1,  S_ADV2  = 38'(1) << 2,
		S_SL    = 38'(1) << 3,  S_SLR   = 38'(1) << 4,  S_BL    = 38'(1) << 5,
		S_BL2   = 38'(1) << 6,  S_TRD   = 38'(1) << 7,  S_TRS   = 38'(1) << 8,
		S_TRM   = 38'(1) << 9,  S_TRA   = 38'(1) << 10, S_TRR   = 38'(1) << 11,
		S_TRE   = 38'(1) << 12, S_TRX   = 38'(1) << 13, S_G1    = 38'(1) << 14,
		S_G2    = 38'(1) << 15, S_G3    = 38'(1) << 16, S_A1    = 38'(1) << 17,
		S_A2    = 38'(1) << 18, S_A3    = 38'(1) << 19, S_B1    = 38'(1) << 20,
		S_B2    = 38'(1) << 21, S_B3    = 38'(1) << 22, S_B4    = 38'(1) << 23,
		S_B5    = 38'(1) << 24, S_C1    = 38'(1) << 25, S_C2    = 38'(1) << 26,
		S_C3    = 38'(1) << 27, S_C4    = 38'(1) << 28, S_C5    = 38'(1) << 29,
		S_C6    = 38'(1) << 30, S_C7    = 38'(1) << 31, S_LIM1  = 38'(1) << 32,
		S_LIM2  = 38'(1) << 33, S_RT    = 38'(1) << 34, S_RT2   = 38'(1) << 35,
		S_FIN   = 38'(1) << 36, S_DWAIT = 38'(1) << 37
	} state_t;

	state_t state_q, ret_q;

	// Configuration
	logic        [1:0]  law_q;
	logic        [30:0] tau_q;
	logic signed [31:0] target_q;
	logic        [30:0] scale_q;
	logic        [30:0] cl_q;
	logic        [30:0] cap_q;
	logic        [16:0] blend_q;

	// Persistent state
	logic signed [31:0] vel_q, rate_q, est_q, prev_q;
	logic               prev_valid_q;
	logic [phvc_pkg::FILL_W-1:0] fill_q;
	logic               fault_q;
	logic               out_valid_q;
	logic [phvc_pkg::CNT_W-1:0] cnt_q;

	// Request and working registers
	logic signed [31:0] coft_q;
	logic        [30:0] dt_q;
	logic        [47:0] now_q;
	logic               first_q;
	logic signed [31:0] vold_q, sl_q, g_q, r1_q, r2_q, r3_q;
	logic signed [51:0] integ_q, acc_q;
	logic        [47:0] ht_q [phvc_pkg::HIST_LEN];
	logic signed [31:0] hv_q [phvc_pkg::HIST_LEN];
	logic signed [31:0] hm_q [phvc_pkg::HIST_LEN];
	phvc_pkg::out_t     out_q;

	// Shared multiplier
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q;
	logic signed [49:0] prod_sh;

	phvc_pkg::div_req_t div_req;
	phvc_pkg::div_rsp_t div_rsp;
	logic signed [31:0] quo;

	logic signed [51:0] dt_w, vel_w, tau_w, lim_x, lim_lo, lim_hi, cap_w;
	logic signed [31:0] base;
	logic               issue_div;

	logic in_fire;
	assign in_fire = in_valid && !in_stall;

	assign quo     = div_rsp.quo;
	assign prod_sh = signed'(prod_q[65:16]);
	assign dt_w    = 52'(signed'({1'b0, dt_q}));
	assign vel_w   = 52'(vel_q);
	assign tau_w   = 52'(signed'({1'b0, tau_q}));
	assign base    = (vel_q > phvc_pkg::ONE_Q) ? vel_q : phvc_pkg::ONE_Q;

	phvc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Operand selection for the multiplier and the divider.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req.num = '0;
		div_req.den = '0;
		issue_div = 1'b0;
		unique case (state_q)
			S_ADV: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(rate_q);
			end
			S_ADV2: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(signed'({1'b0, scale_q}));
			end
			S_SL: begin
				div_req.num = 52'(coft_q) - 52'(prev_q);
				div_req.den = prod_sh;
				issue_div = 1'b1;
			end
			S_BL: begin
				mul_a = 33'(signed'({1'b0, blend_q}));
				mul_b = 33'(sl_q) - 33'(est_q);
			end
			S_TRD: begin
				div_req.num = 52'(hm_q[0]) - 52'(hm_q[phvc_pkg::AVG_POINTS]);
				div_req.den = 50'(signed'({1'b0, scale_q}));
				issue_div = 1'b1;
			end
			S_TRM: begin
				mul_a = (33'(hv_q[0]) + 33'(hv_q[1])) >>> 1;
				mul_b = 33'(phvc_pkg::sat32(52'(signed'({1'b0, ht_q[0]}))
					- 52'(signed'({1'b0, ht_q[1]}))));
			end
			S_TRE: begin
				div_req.num = integ_q - 52'(r1_q);
				div_req.den = 50'(signed'({1'b0, ht_q[0]}))
					- 50'(signed'({1'b0, ht_q[phvc_pkg::AVG_POINTS]}));
				issue_div = 1'b1;
			end
			S_G1: begin
				mul_a = 33'(signed'({1'b0, scale_q}));
				mul_b = 33'(signed'({1'b0, tau_q}));
			end
			S_G2: begin
				div_req.num = 52'(target_q) - 52'(coft_q);
				div_req.den = prod_sh;
				issue_div = 1'b1;
			end
			S_A1, S_C1: begin
				div_req.num = 52'(g_q) <<< 1;
				div_req.den = 50'(tau_w);
				issue_div = 1'b1;
			end
			S_B1: begin
				div_req.num = 52'(g_q) * 52'sd3;
				div_req.den = 50'(tau_w);
				issue_div = 1'b1;
			end
			S_A2, S_C4: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(quo);
			end
			S_B2: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(dt_w);
			end
			S_B3: begin
				div_req.num = 52'(prod_sh) >>> 1;
				div_req.den = 50'(tau_w);
				issue_div = 1'b1;
			end
			S_B4: begin
				mul_a = 33'(phvc_pkg::sat32(dt_w - 52'(quo)));
				mul_b = 33'(r1_q);
			end
			S_C2: begin
				div_req.num = 52'(phvc_pkg::sat32(52'(est_q) - vel_w));
				div_req.den = 50'(tau_w);
				issue_div = 1'b1;
			end
			S_C3: begin
				div_req.num = (52'(quo) - 52'(r1_q)) * 52'sd6;
				div_req.den = 50'(tau_w);
				issue_div = 1'b1;
			end
			S_C5: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(r3_q);
			end
			S_C6: begin
				mul_a = 33'(dt_w);
				mul_b = 33'(r1_q);
			end
			S_LIM1: begin
				mul_a = 33'(signed'({1'b0, cl_q}));
				mul_b = 33'(base);
			end
			S_RT: begin
				div_req.num = 52'(r2_q) - vel_w;
				div_req.den = 50'(dt_w);
				issue_div = !first_q;
			end
			S_IDLE, S_SLR, S_BL2, S_TRS, S_TRA, S_TRR, S_TRX, S_G3, S_A3, S_B5,
			S_C7, S_LIM2, S_RT2, S_FIN, S_DWAIT: begin
			end
			default: begin
			end
		endcase
		div_req.start = issue_div;
	end

	// Output limits: non-negative, step window, then the optional cap.
	always_comb begin
		lim_lo = vel_w - 52'(prod_sh);
		lim_hi = vel_w + 52'(signed'({1'b0, cl_q}));
		cap_w  = 52'(signed'({1'b0, cap_q}));
		lim_x  = 52'(r1_q);
		if (lim_x < 0) begin
			lim_x = '0;
		end
		if (lim_x < lim_lo) begin
			lim_x = lim_lo;
		end
		if (lim_x > lim_hi) begin
			lim_x = lim_hi;
		end
		if (cap_q != 0 && lim_x > cap_w) begin
			lim_x = cap_w;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			law_q        <= phvc_pkg::LAW_LINEAR;
			tau_q        <= 31'd65536;
			target_q     <= '0;
			scale_q      <= 31'd65536;
			cl_q         <= 31'd65536;
			cap_q        <= '0;
			blend_q      <= '0;
			vel_q        <= '0;
			rate_q       <= '0;
			est_q        <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			fill_q       <= phvc_pkg::FILL_W'(phvc_pkg::HIST_LEN);
			fault_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					phvc_pkg::CFG_LAW:      law_q    <= cfg_data[1:0];
					phvc_pkg::CFG_TAU:      tau_q    <= cfg_data[30:0];
					phvc_pkg::CFG_TARGET:   target_q <= signed'(cfg_data);
					phvc_pkg::CFG_SCALE:    scale_q  <= cfg_data[30:0];
					phvc_pkg::CFG_LIMIT:    cl_q     <= cfg_data[30:0];
					phvc_pkg::CFG_CAP:      cap_q    <= cfg_data[30:0];
					phvc_pkg::CFG_BLEND:    blend_q  <= cfg_data[16:0];
					// The initial velocity only matters at reset, where it is zero.
					phvc_pkg::CFG_INIT_VEL: begin
					end
					default: begin
					end
				endcase
			end

			// The last state loads the next result itself when the old one leaves.
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fault_q <= 1'b0;
						if (in_data.first_step) begin
							fill_q <= phvc_pkg::FILL_W'(phvc_pkg::HIST_LEN);
						end
						if (!prev_valid_q) begin
							prev_q       <= in_data.measured_position;
							prev_valid_q <= 1'b1;
						end
						state_q <= S_ADV;
					end
				end
				S_ADV: state_q <= S_ADV2;
				S_ADV2: begin
					if (dt_q != 0) begin
						vel_q <= phvc_pkg::sat32(vel_w + 52'(prod_sh));
					end
					state_q <= S_SL;
				end
				S_SL: begin
					ret_q   <= S_SLR;
					state_q <= S_DWAIT;
				end
				S_SLR: begin
					if (fill_q == 0) begin
						state_q <= S_TRD;
					end else begin
						fill_q  <= fill_q - 1'b1;
						state_q <= first_q ? S_G1 : S_BL;
					end
				end
				S_BL: state_q <= S_BL2;
				S_BL2: begin
					est_q   <= phvc_pkg::sat32(52'(est_q) + 52'(prod_sh));
					state_q <= S_G1;
				end
				S_TRD: begin
					cnt_q   <= '0;
					ret_q   <= S_TRS;
					state_q <= S_DWAIT;
				end
				S_TRS: state_q <= S_TRM;
				S_TRM: state_q <= S_TRA;
				S_TRA: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == phvc_pkg::CNT_W'(phvc_pkg::AVG_POINTS - 1)) begin
						state_q <= S_TRR;
					end else begin
						state_q <= S_TRM;
					end
				end
				S_TRR: state_q <= S_TRE;
				S_TRE: begin
					ret_q   <= S_TRX;
					state_q <= S_DWAIT;
				end
				S_TRX: begin
					est_q   <= quo;
					state_q <= S_G1;
				end
				S_G1: state_q <= S_G2;
				S_G2: begin
					ret_q   <= S_G3;
					state_q <= S_DWAIT;
				end
				S_G3: begin
					case (law_q)
						phvc_pkg::LAW_LINEAR: state_q <= S_A1;
						phvc_pkg::LAW_QUAD1:  state_q <= S_B1;
						phvc_pkg::LAW_QUAD2:  state_q <= S_C1;
						default:              state_q <= S_LIM1;
					endcase
				end
				S_A1: begin
					ret_q   <= S_A2;
					state_q <= S_DWAIT;
				end
				S_A2: state_q <= S_A3;
				S_A3: state_q <= S_LIM1;
				S_B1: begin
					ret_q   <= S_B2;
					state_q <= S_DWAIT;
				end
				S_B2: state_q <= S_B3;
				S_B3: begin
					ret_q   <= S_B4;
					state_q <= S_DWAIT;
				end
				S_B4: state_q <= S_B5;
				S_B5: state_q <= S_LIM1;
				S_C1: begin
					ret_q   <= S_C2;
					state_q <= S_DWAIT;
				end
				S_C2: begin
					ret_q   <= S_C3;
					state_q <= S_DWAIT;
				end
				S_C3: begin
					ret_q   <= S_C4;
					state_q <= S_DWAIT;
				end
				S_C4: state_q <= S_C5;
				S_C5: state_q <= S_C6;
				S_C6: state_q <= S_C7;
				S_C7: state_q <= S_LIM1;
				S_LIM1: state_q <= S_LIM2;
				S_LIM2: state_q <= S_RT;
				S_RT: begin
					if (!first_q) begin
						ret_q   <= S_RT2;
						state_q <= S_DWAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RT2: begin
					rate_q  <= quo;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						prev_q      <= coft_q;
						state_q     <= S_IDLE;
					end
				end
				S_DWAIT: begin
					if (div_rsp.done) begin
						fault_q <= fault_q | div_rsp.fault;
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and the history window
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire) begin
			coft_q  <= in_data.measured_position;
			dt_q    <= in_data.time_step;
			now_q   <= in_data.current_time;
			first_q <= in_data.first_step;
		end
		if (state_q == S_ADV2) begin
			vold_q <= vel_q;
		end
		if (state_q == S_SL) begin
			for (int i = phvc_pkg::HIST_LEN - 1; i > 0; i--) begin
				ht_q[i] <= ht_q[i - 1];
				hv_q[i] <= hv_q[i - 1];
				hm_q[i] <= hm_q[i - 1];
			end
			ht_q[0] <= now_q;
			hv_q[0] <= vel_q;
			hm_q[0] <= coft_q;
		end
		// The window rotates once per term and once more to come back in place.
		if (state_q == S_TRM || state_q == S_TRR) begin
			for (int i = 0; i < phvc_pkg::HIST_LEN - 1; i++) begin
				ht_q[i] <= ht_q[i + 1];
				hv_q[i] <= hv_q[i + 1];
				hm_q[i] <= hm_q[i + 1];
			end
			ht_q[phvc_pkg::HIST_LEN - 1] <= ht_q[0];
			hv_q[phvc_pkg::HIST_LEN - 1] <= hv_q[0];
			hm_q[phvc_pkg::HIST_LEN - 1] <= hm_q[0];
		end
		if (state_q == S_SLR) begin
			sl_q <= phvc_pkg::sat32(((52'(vold_q) + vel_w) >>> 1) - 52'(quo));
		end
		if (state_q == S_TRD) begin
			integ_q <= '0;
		end
		if (state_q == S_TRS) begin
			r1_q <= quo;
		end
		if (state_q == S_TRA) begin
			integ_q <= integ_q + 52'(prod_sh);
		end
		if (state_q == S_G3) begin
			g_q   <= phvc_pkg::sat32(52'(quo) + 52'(est_q) - vel_w);
			acc_q <= '0;
		end
		if (state_q == S_A3 || state_q == S_B5 || state_q == S_C6) begin
			acc_q <= vel_w + 52'(prod_sh);
		end
		if (state_q == S_C7) begin
			acc_q <= acc_q + (52'(prod_sh) >>> 1);
		end
		if (state_q == S_B2 || state_q == S_C2) begin
			r1_q <= quo;
		end
		if (state_q == S_C3) begin
			r3_q <= phvc_pkg::sat32(52'(r1_q) * 52'sd3 - (52'(quo) <<< 1));
		end
		if (state_q == S_C5) begin
			r1_q <= phvc_pkg::sat32(52'(prod_sh));
		end
		if (state_q == S_LIM1) begin
			r1_q <= phvc_pkg::sat32(acc_q);
		end
		if (state_q == S_LIM2) begin
			r2_q <= phvc_pkg::sat32(lim_x);
		end
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			out_q.inlet_velocity   <= vel_q;
			out_q.velocity_rate    <= rate_q;
			out_q.speed_estimate   <= est_q;
			out_q.local_speed      <= sl_q;
			out_q.clamped_velocity <= r2_q;
			out_q.divide_fault     <= fault_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
